// ===== sv/dapdc_pkg.sv =====
// Shared types and constants for the dual-axis PI duty controller.
// Used by the axis datapath, the top level and the testbench.
`timescale 1ns / 1ps

package dapdc_pkg;

  localparam int WORD_W    = 32;
  localparam int FIELD_W   = 16;
  localparam int GAIN_W    = 16;
  localparam int DUTY_W    = 7;
  localparam int ALT_ERR_W = 34;
  localparam int REG_IDX_W = 3;
  localparam int CMD_W     = 2;

  // Request opcodes.
  localparam logic [CMD_W-1:0] CMD_CTRL     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_YAW_STEP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ALT_STEP = 2'd2;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_ALT_KP      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ALT_KI      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_YAW_KP      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_YAW_KI      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CTRL_RATE   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MAIN_HOVER  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TAIL_HOVER  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_DUTY_CEIL   = 3'd7;

  // Register reset values.
  localparam logic [GAIN_W-1:0] RST_ALT_KP     = 16'd32768;
  localparam logic [GAIN_W-1:0] RST_ALT_KI     = 16'd13107;
  localparam logic [GAIN_W-1:0] RST_YAW_KP     = 16'd32768;
  localparam logic [GAIN_W-1:0] RST_YAW_KI     = 16'd19661;
  localparam logic [GAIN_W-1:0] RST_CTRL_RATE  = 16'd100;
  localparam logic [DUTY_W-1:0] RST_MAIN_HOVER = 7'd50;
  localparam logic [DUTY_W-1:0] RST_TAIL_HOVER = 7'd35;
  localparam logic [DUTY_W-1:0] RST_DUTY_CEIL  = 7'd95;

  // Target stepping limits.
  localparam int                       DEG_PER_TURN = 360;
  localparam logic signed [WORD_W-1:0] DEG_TURN_S   = 32'sd360;
  localparam logic signed [WORD_W-1:0] YAW_WRAP_HI  = 32'sd181;
  localparam logic signed [WORD_W-1:0] YAW_WRAP_LO  = -32'sd179;
  localparam logic signed [WORD_W-1:0] ALT_STEP_TOP = 32'sd90;

  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

  // Per-axis settings handed to one PI datapath.
  typedef struct packed {
    logic [GAIN_W-1:0] p_gain;
    logic [GAIN_W-1:0] i_gain;
    logic [GAIN_W-1:0] rate;
    logic [DUTY_W-1:0] hover;
    logic [DUTY_W-1:0] ceiling;
  } axis_cfg_t;

endpackage

// ===== sv/dapdc_sdiv.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
// Standalone; used by the axis datapath and the yaw target scaler.
`timescale 1ns / 1ps

module dapdc_sdiv #(
  parameter int NW = 34,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [NW-1:0] quot,
  output logic          rem_nz
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial  = {rem, quo[NW-1]};
  assign ge     = trial >= {1'b0, dvs};
  assign diff   = trial - {1'b0, dvs};
  assign quot   = quo;
  assign rem_nz = rem != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CW'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
      cnt <= CW'(NW);
    end else if (busy) begin
      // The remainder stays below the divisor, so the difference fits DW bits.
      quo <= {quo[NW-2:0], ge};
      rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
      cnt <= cnt - CW'(1);
    end
  end

endmodule

// ===== sv/dapdc_axis.sv =====
// One PI axis: serial gain multiplies, serial integral divide, clamp.
// Depends on dapdc_pkg and dapdc_sdiv. Holds the axis integral and duty.
`timescale 1ns / 1ps

module dapdc_axis
  import dapdc_pkg::*;
#(
  parameter int ERR_W = 34
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [ERR_W-1:0]  err,
  input  axis_cfg_t                cfg,
  output logic                     busy,
  output logic signed [WORD_W-1:0] duty
);

  localparam int PW  = ERR_W + GAIN_W;
  localparam int PRW = ERR_W + 2;
  localparam int SW  = ERR_W + 2;
  localparam int TW  = PRW + 1;
  localparam int MCW = $clog2(GAIN_W);

  localparam logic signed [SW-1:0] S_ONE = SW'(1);
  localparam logic signed [SW-1:0] S_MAX = {{(SW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {{(SW-31){1'b1}}, {31{1'b0}}};
  localparam logic signed [TW-1:0] T_MIN = {{(TW-31){1'b1}}, {31{1'b0}}};

  typedef enum logic [3:0] {
    AX_IDLE = 4'b0001,
    AX_MUL  = 4'b0010,
    AX_DIV  = 4'b0100,
    AX_FIN  = 4'b1000
  } ax_phase_t;

  ax_phase_t               phase;
  logic [ERR_W-1:0]        mag;
  logic [ERR_W-1:0]        mag_in;
  logic                    neg;
  logic [GAIN_W-1:0]       pg_sr;
  logic [GAIN_W-1:0]       ig_sr;
  logic [PW-1:0]           prod_p;
  logic [PW-1:0]           prod_i;
  logic [PW-1:0]           prod_p_next;
  logic [PW-1:0]           prod_i_next;
  logic [MCW-1:0]          mcnt;
  logic signed [PRW-1:0]   prop;
  logic signed [PRW-1:0]   prop_c;
  logic signed [PW:0]      sp;
  logic signed [PW+1:0]    vsum;
  logic signed [WORD_W-1:0] integral;
  logic signed [WORD_W-1:0] integral_next;
  logic                    div_start;
  logic                    div_busy;
  logic [ERR_W-1:0]        quot;
  logic                    rem_nz;
  logic                    inexact;
  logic signed [SW-1:0]    q_ext;
  logic signed [SW-1:0]    q_s;
  logic signed [SW-1:0]    acc_sum;
  logic signed [SW-1:0]    acc_adj;
  logic signed [TW-1:0]    total;
  logic signed [TW-1:0]    ceil_t;
  logic signed [WORD_W-1:0] duty_c;

  assign busy   = phase != AX_IDLE;
  assign mag_in = err[ERR_W-1] ? $unsigned(-err) : $unsigned(err);

  // MSB-first shift-add: one gain bit per cycle for both products.
  assign prod_p_next = {prod_p[PW-2:0], 1'b0} + (pg_sr[GAIN_W-1] ? PW'(mag) : PW'(0));
  assign prod_i_next = {prod_i[PW-2:0], 1'b0} + (ig_sr[GAIN_W-1] ? PW'(mag) : PW'(0));
  assign div_start   = (phase == AX_MUL) && (mcnt == '0);

  // The low 16 product bits are the Q0.16 scale; the divider works on the rest.
  dapdc_sdiv #(
    .NW (ERR_W),
    .DW (GAIN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_i_next[PW-1:GAIN_W]),
    .divisor  (cfg.rate),
    .busy     (div_busy),
    .quot     (quot),
    .rem_nz   (rem_nz)
  );

  // Proportional term: hover plus signed product, truncated toward zero.
  always_comb begin
    sp     = neg ? -$signed({1'b0, prod_p}) : $signed({1'b0, prod_p});
    vsum   = (PW+2)'(sp) + (PW+2)'($signed({1'b0, cfg.hover, 16'h0}));
    prop_c = $signed(vsum[PW+1:GAIN_W])
           + PRW'((vsum[PW+1] && vsum[GAIN_W-1:0] != '0) ? 1 : 0);
  end

  // Integral: the whole sum is truncated toward zero, then saturated.
  always_comb begin
    inexact = (prod_i[GAIN_W-1:0] != '0) || rem_nz;
    q_ext   = $signed({2'b00, quot});
    q_s     = neg ? -q_ext : q_ext;
    acc_sum = SW'(integral) + q_s;
    acc_adj = acc_sum;
    if (inexact && neg && acc_sum > 0) begin
      acc_adj = acc_sum - S_ONE;
    end else if (inexact && !neg && acc_sum < 0) begin
      acc_adj = acc_sum + S_ONE;
    end
    if (acc_adj > S_MAX) begin
      integral_next = WORD_MAX;
    end else if (acc_adj < S_MIN) begin
      integral_next = WORD_MIN;
    end else begin
      integral_next = WORD_W'(acc_adj);
    end
  end

  // Duty is clamped above at the ceiling and saturated below.
  always_comb begin
    total  = TW'(prop) + TW'(integral);
    ceil_t = $signed({{(TW-DUTY_W){1'b0}}, cfg.ceiling});
    if (total > ceil_t) begin
      duty_c = WORD_W'(ceil_t);
    end else if (total < T_MIN) begin
      duty_c = WORD_MIN;
    end else begin
      duty_c = WORD_W'(total);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= AX_IDLE;
      integral <= '0;
      duty     <= '0;
    end else begin
      unique case (phase)
        AX_IDLE: begin
          if (start) begin
            phase <= AX_MUL;
          end
        end
        AX_MUL: begin
          if (mcnt == '0) begin
            phase <= AX_DIV;
          end
        end
        AX_DIV: begin
          if (!div_busy) begin
            if (cfg.rate != '0) begin
              integral <= integral_next;
            end
            phase <= AX_FIN;
          end
        end
        AX_FIN: begin
          duty  <= duty_c;
          phase <= AX_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (phase == AX_IDLE && start) begin
      mag    <= mag_in;
      neg    <= err[ERR_W-1];
      pg_sr  <= cfg.p_gain;
      ig_sr  <= cfg.i_gain;
      prod_p <= '0;
      prod_i <= '0;
      mcnt   <= MCW'(GAIN_W - 1);
    end else if (phase == AX_MUL) begin
      prod_p <= prod_p_next;
      prod_i <= prod_i_next;
      pg_sr  <= {pg_sr[GAIN_W-2:0], 1'b0};
      ig_sr  <= {ig_sr[GAIN_W-2:0], 1'b0};
      mcnt   <= mcnt - MCW'(1);
    end
    if (phase == AX_DIV) begin
      prop <= prop_c;
    end
  end

endmodule

// ===== sv/dual_axis_pi_duty_controller_unit.sv =====
// Dual-axis PI duty controller. One request in flight; each result is held in
// an output register, and the next request is taken while it waits.
// Control step: serial gain multiplies, then the bit-serial integral divide, on
// both axes at once. Yaw step: the target is scaled to encoder edges by a serial
// multiply and divide. Altitude step and unused opcode go straight to the result.
// Synchronous reset covers state, targets, integrals and settings, not output data.
`timescale 1ns / 1ps

module dual_axis_pi_duty_controller_unit
  import dapdc_pkg::*;
#(
  parameter int EDGES_PER_TURN = 448
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic [CMD_W-1:0]         cmd,
  input  logic signed [FIELD_W-1:0] altitude_pct,
  input  logic signed [FIELD_W-1:0] yaw_count,
  input  logic signed [FIELD_W-1:0] target_step,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic signed [WORD_W-1:0] main_duty,
  output logic signed [WORD_W-1:0] tail_duty,
  output logic signed [WORD_W-1:0] yaw_goal,
  output logic signed [WORD_W-1:0] altitude_goal,
  input  logic                     cfg_we,
  input  logic [REG_IDX_W-1:0]     cfg_index,
  input  logic [GAIN_W-1:0]        cfg_data
);

  localparam int EW  = $clog2(EDGES_PER_TURN + 1);
  localparam int SCW = $clog2(EW + 1);
  localparam int SPW = WORD_W + EW;
  localparam int YSW = SPW + 1;
  localparam int YEW = YSW + 1;
  localparam int DVW = $clog2(DEG_PER_TURN + 1);

  typedef enum logic [5:0] {
    S_IDLE       = 6'b000001,
    S_SCALE_LOAD = 6'b000010,
    S_SCALE_MUL  = 6'b000100,
    S_SCALE_DIV  = 6'b001000,
    S_CTRL       = 6'b010000,
    S_HOLD       = 6'b100000
  } state_t;

  state_t state;

  logic [GAIN_W-1:0] alt_kp, alt_ki, yaw_kp, yaw_ki, control_rate;
  logic [DUTY_W-1:0] main_hover_duty, tail_hover_duty, duty_ceiling;

  logic signed [WORD_W-1:0]    alt_target;
  logic signed [WORD_W-1:0]    yaw_target;
  logic signed [YSW-1:0]       yaw_scaled;
  logic                        item_accept;
  logic                        ctrl_start;
  logic                        result_load;
  logic signed [ALT_ERR_W-1:0] alt_err;
  logic signed [YEW-1:0]       yaw_err;
  logic signed [WORD_W:0]      alt_sum;
  logic signed [WORD_W-1:0]    alt_sat;
  logic                        alt_ok;
  logic signed [WORD_W-1:0]    yaw_sum;
  logic signed [WORD_W-1:0]    yaw_wrap;
  logic [WORD_W-1:0]           smag;
  logic                        sneg;
  logic [EW-1:0]               esr;
  logic [SPW-1:0]              sprod;
  logic [SPW-1:0]              sprod_next;
  logic [SCW-1:0]              scnt;
  logic                        sdiv_start;
  logic                        sdiv_busy;
  logic [SPW-1:0]              squot;
  logic                        srem_nz;
  logic signed [YSW-1:0]       yq;
  axis_cfg_t                   alt_cfg;
  axis_cfg_t                   yaw_cfg;
  logic                        alt_busy;
  logic                        yaw_busy;
  logic signed [WORD_W-1:0]    alt_duty;
  logic signed [WORD_W-1:0]    yaw_duty;

  assign item_stall  = state != S_IDLE;
  assign item_accept = item_valid && (state == S_IDLE);
  assign ctrl_start  = item_accept && (cmd == CMD_CTRL);
  assign result_load = (state == S_HOLD) && (!result_valid || !result_stall);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      alt_kp          <= RST_ALT_KP;
      alt_ki          <= RST_ALT_KI;
      yaw_kp          <= RST_YAW_KP;
      yaw_ki          <= RST_YAW_KI;
      control_rate    <= RST_CTRL_RATE;
      main_hover_duty <= RST_MAIN_HOVER;
      tail_hover_duty <= RST_TAIL_HOVER;
      duty_ceiling    <= RST_DUTY_CEIL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALT_KP:     alt_kp          <= cfg_data;
        REG_ALT_KI:     alt_ki          <= cfg_data;
        REG_YAW_KP:     yaw_kp          <= cfg_data;
        REG_YAW_KI:     yaw_ki          <= cfg_data;
        REG_CTRL_RATE:  control_rate    <= cfg_data;
        REG_MAIN_HOVER: main_hover_duty <= cfg_data[DUTY_W-1:0];
        REG_TAIL_HOVER: tail_hover_duty <= cfg_data[DUTY_W-1:0];
        REG_DUTY_CEIL:  duty_ceiling    <= cfg_data[DUTY_W-1:0];
      endcase
    end
  end

  assign alt_cfg = '{p_gain: alt_kp, i_gain: alt_ki, rate: control_rate,
                     hover: main_hover_duty, ceiling: duty_ceiling};
  assign yaw_cfg = '{p_gain: yaw_kp, i_gain: yaw_ki, rate: control_rate,
                     hover: tail_hover_duty, ceiling: duty_ceiling};

  assign alt_err = ALT_ERR_W'(alt_target) - ALT_ERR_W'(altitude_pct);
  assign yaw_err = YEW'(yaw_scaled) - YEW'(yaw_count);

  // Altitude step: applied only when moving down from above zero or up from
  // at most the top limit.
  always_comb begin
    alt_ok  = (alt_target > 0 && target_step < 0)
           || (alt_target <= ALT_STEP_TOP && target_step > 0);
    alt_sum = (WORD_W+1)'(alt_target) + (WORD_W+1)'(target_step);
    if (alt_sum[WORD_W] != alt_sum[WORD_W-1]) begin
      alt_sat = alt_sum[WORD_W] ? WORD_MIN : WORD_MAX;
    end else begin
      alt_sat = alt_sum[WORD_W-1:0];
    end
  end

  // Yaw step wraps once by one turn when the sum is above 180 or at or below -179.
  always_comb begin
    yaw_sum = yaw_target + WORD_W'(target_step);
    if (yaw_sum >= YAW_WRAP_HI) begin
      yaw_wrap = yaw_sum - DEG_TURN_S;
    end else if (yaw_sum <= YAW_WRAP_LO) begin
      yaw_wrap = yaw_sum + DEG_TURN_S;
    end else begin
      yaw_wrap = yaw_sum;
    end
  end

  // The yaw target in encoder edges is kept alongside the target in degrees.
  assign sprod_next = {sprod[SPW-2:0], 1'b0} + (esr[EW-1] ? SPW'(smag) : SPW'(0));
  assign sdiv_start = (state == S_SCALE_MUL) && (scnt == '0);
  assign yq         = $signed({1'b0, squot});

  dapdc_sdiv #(
    .NW (SPW),
    .DW (DVW)
  ) u_scale_div (
    .clk      (clk),
    .rst      (rst),
    .start    (sdiv_start),
    .dividend (sprod_next),
    .divisor  (DVW'(DEG_PER_TURN)),
    .busy     (sdiv_busy),
    .quot     (squot),
    .rem_nz   (srem_nz)
  );

  dapdc_axis #(
    .ERR_W (ALT_ERR_W)
  ) u_alt (
    .clk   (clk),
    .rst   (rst),
    .start (ctrl_start),
    .err   (alt_err),
    .cfg   (alt_cfg),
    .busy  (alt_busy),
    .duty  (alt_duty)
  );

  dapdc_axis #(
    .ERR_W (YEW)
  ) u_yaw (
    .clk   (clk),
    .rst   (rst),
    .start (ctrl_start),
    .err   (yaw_err),
    .cfg   (yaw_cfg),
    .busy  (yaw_busy),
    .duty  (yaw_duty)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      alt_target <= '0;
      yaw_target <= '0;
      yaw_scaled <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_accept) begin
            unique case (cmd)
              CMD_CTRL: state <= S_CTRL;
              CMD_YAW_STEP: begin
                yaw_target <= yaw_wrap;
                state      <= S_SCALE_LOAD;
              end
              CMD_ALT_STEP: begin
                if (alt_ok) begin
                  alt_target <= alt_sat;
                end
                state <= S_HOLD;
              end
              default: state <= S_HOLD;
            endcase
          end
        end
        S_SCALE_LOAD: state <= S_SCALE_MUL;
        S_SCALE_MUL: begin
          if (scnt == '0) begin
            state <= S_SCALE_DIV;
          end
        end
        S_SCALE_DIV: begin
          if (!sdiv_busy) begin
            yaw_scaled <= sneg ? -yq : yq;
            state      <= S_HOLD;
          end
        end
        S_CTRL: begin
          if (!alt_busy && !yaw_busy) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (result_load) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  // Serial multiply of the target magnitude by the edge count per turn.
  always_ff @(posedge clk) begin
    if (state == S_SCALE_LOAD) begin
      smag  <= yaw_target[WORD_W-1] ? $unsigned(-yaw_target) : $unsigned(yaw_target);
      sneg  <= yaw_target[WORD_W-1];
      esr   <= EW'(EDGES_PER_TURN);
      sprod <= '0;
      scnt  <= SCW'(EW - 1);
    end else if (state == S_SCALE_MUL) begin
      sprod <= sprod_next;
      esr   <= esr << 1;
      scnt  <= scnt - SCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      main_duty     <= alt_duty;
      tail_duty     <= yaw_duty;
      yaw_goal      <= yaw_target;
      altitude_goal <= alt_target;
    end
  end

endmodule

// ===== test/tb_dual_axis_pi_duty_controller_unit.sv =====
// Self-checking testbench for the dual-axis PI duty controller.
// Holds its own bit-exact model of both PI loops and the target stepping,
// and depends on dapdc_pkg and dual_axis_pi_duty_controller_unit.
`timescale 1ns / 1ps

module tb_dual_axis_pi_duty_controller_unit;
  import dapdc_pkg::*;

  localparam int EDGES_PER_TURN = 448;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 85;
  localparam logic [CMD_W-1:0] CMD_IDLE_OP = 2'd3;

  typedef enum int {SET_ZERO, SET_FULL, SET_FAST_I, SET_RANDOM} setting_kind_t;

  typedef struct {
    logic signed [WORD_W-1:0] main_duty;
    logic signed [WORD_W-1:0] tail_duty;
    logic signed [WORD_W-1:0] yaw_goal;
    logic signed [WORD_W-1:0] altitude_goal;
  } duty_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [CMD_W-1:0] cmd = '0;
  logic signed [FIELD_W-1:0] altitude_pct = '0;
  logic signed [FIELD_W-1:0] yaw_count = '0;
  logic signed [FIELD_W-1:0] target_step = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [WORD_W-1:0] main_duty;
  logic signed [WORD_W-1:0] tail_duty;
  logic signed [WORD_W-1:0] yaw_goal;
  logic signed [WORD_W-1:0] altitude_goal;
  logic cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0] cfg_data = '0;

  // Settings as the block should hold them.
  logic [GAIN_W-1:0] alt_p = RST_ALT_KP;
  logic [GAIN_W-1:0] alt_i = RST_ALT_KI;
  logic [GAIN_W-1:0] yaw_p = RST_YAW_KP;
  logic [GAIN_W-1:0] yaw_i = RST_YAW_KI;
  logic [GAIN_W-1:0] rate  = RST_CTRL_RATE;
  logic [DUTY_W-1:0] main_hover = RST_MAIN_HOVER;
  logic [DUTY_W-1:0] tail_hover = RST_TAIL_HOVER;
  logic [DUTY_W-1:0] ceiling    = RST_DUTY_CEIL;

  // Controller state as the block should hold it.
  logic signed [WORD_W-1:0] alt_accum = '0;
  logic signed [WORD_W-1:0] yaw_accum = '0;
  logic signed [WORD_W-1:0] alt_goal = '0;
  logic signed [WORD_W-1:0] yaw_goal_deg = '0;
  logic signed [WORD_W-1:0] main_duty_now = '0;
  logic signed [WORD_W-1:0] tail_duty_now = '0;

  duty_result_t pending_results[$];
  duty_result_t want;
  int mismatches = 0;
  int results_checked = 0;
  int requests_sent = 0;
  int settings_applied = 0;
  int cycle_count = 0;
  int stall_left = 0;
  int hold_request = 0;
  bit quiet_sender = 1'b0;
  bit quiet_receiver = 1'b0;

  dual_axis_pi_duty_controller_unit #(
    .EDGES_PER_TURN(EDGES_PER_TURN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .cmd(cmd),
    .altitude_pct(altitude_pct),
    .yaw_count(yaw_count),
    .target_step(target_step),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .main_duty(main_duty),
    .tail_duty(tail_duty),
    .yaw_goal(yaw_goal),
    .altitude_goal(altitude_goal),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  function automatic logic signed [WORD_W-1:0] clip_word(input longint v);
    if (v > longint'(WORD_MAX)) return WORD_MAX;
    if (v < longint'(WORD_MIN)) return WORD_MIN;
    return v[WORD_W-1:0];
  endfunction

  // The whole sum acc + err * igain / (65536 * rate) is truncated toward zero.
  function automatic logic signed [WORD_W-1:0] next_integral(
      input logic signed [WORD_W-1:0] acc, input longint err,
      input logic [GAIN_W-1:0] igain);
    longint num, den, q, r, s;
    if (rate == 0) return acc;
    num = err * longint'(igain);
    den = longint'(rate) * 65536;
    q = num / den;
    r = num - q * den;
    s = longint'(acc) + q;
    if (r < 0 && s > 0) s = s - 1;
    else if (r > 0 && s < 0) s = s + 1;
    return clip_word(s);
  endfunction

  function automatic logic signed [WORD_W-1:0] axis_duty(
      input longint err, input logic [DUTY_W-1:0] hover,
      input logic [GAIN_W-1:0] pgain, input logic signed [WORD_W-1:0] acc);
    longint prop, total;
    prop = (longint'(hover) * 65536 + err * longint'(pgain)) / 65536;
    total = prop + longint'(acc);
    if (total > longint'(ceiling)) total = longint'(ceiling);
    return clip_word(total);
  endfunction

  task automatic predict_step(input logic [CMD_W-1:0] op,
                              input logic signed [FIELD_W-1:0] alt_meas,
                              input logic signed [FIELD_W-1:0] yaw_meas,
                              input logic signed [FIELD_W-1:0] step);
    longint alt_err, yaw_err;
    logic signed [WORD_W-1:0] t;
    duty_result_t res;
    case (op)
      CMD_CTRL: begin
        alt_err = longint'(alt_goal) - longint'(alt_meas);
        yaw_err = (longint'(yaw_goal_deg) * EDGES_PER_TURN) / DEG_PER_TURN
                  - longint'(yaw_meas);
        alt_accum = next_integral(alt_accum, alt_err, alt_i);
        yaw_accum = next_integral(yaw_accum, yaw_err, yaw_i);
        main_duty_now = axis_duty(alt_err, main_hover, alt_p, alt_accum);
        tail_duty_now = axis_duty(yaw_err, tail_hover, yaw_p, yaw_accum);
      end
      CMD_YAW_STEP: begin
        // The wrap by one turn, above 180 or at or below -179, is applied once only.
        t = yaw_goal_deg + WORD_W'(step);
        if (t >= YAW_WRAP_HI) t = t - DEG_TURN_S;
        else if (t <= YAW_WRAP_LO) t = t + DEG_TURN_S;
        yaw_goal_deg = t;
      end
      CMD_ALT_STEP: begin
        if ((alt_goal > 0 && step < 0) || (alt_goal <= ALT_STEP_TOP && step > 0))
          alt_goal = clip_word(longint'(alt_goal) + longint'(step));
      end
      default: ;
    endcase
    res.main_duty = main_duty_now;
    res.tail_duty = tail_duty_now;
    res.yaw_goal = yaw_goal_deg;
    res.altitude_goal = alt_goal;
    pending_results.push_back(res);
  endtask

  // ---------------------------------------------------------------- driving

  function automatic int draw_wait(input bit quiet);
    return quiet ? 0 : int'($urandom_range(7));
  endfunction

  // Leaves the request valid on return unless a random gap follows; the next call or a drain lowers it.
  task automatic send_request(input logic [CMD_W-1:0] op,
                              input logic signed [FIELD_W-1:0] alt_meas,
                              input logic signed [FIELD_W-1:0] yaw_meas,
                              input logic signed [FIELD_W-1:0] step);
    int gap;
    item_valid <= 1'b1;
    cmd <= op;
    altitude_pct <= alt_meas;
    yaw_count <= yaw_meas;
    target_step <= step;
    do @(posedge clk); while (item_stall);
    predict_step(op, alt_meas, yaw_meas, step);
    requests_sent++;
    gap = draw_wait(quiet_sender);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_pending();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                input logic [GAIN_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_ALT_KP:     alt_p = value;
      REG_ALT_KI:     alt_i = value;
      REG_YAW_KP:     yaw_p = value;
      REG_YAW_KI:     yaw_i = value;
      REG_CTRL_RATE:  rate = value;
      REG_MAIN_HOVER: main_hover = value[DUTY_W-1:0];
      REG_TAIL_HOVER: tail_hover = value[DUTY_W-1:0];
      REG_DUTY_CEIL:  ceiling = value[DUTY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input setting_kind_t kind);
    logic [GAIN_W-1:0] ap, ai, yp, yi, rt;
    logic [GAIN_W-1:0] mh, th, dc;
    ap = 16'($urandom);
    ai = 16'($urandom);
    yp = 16'($urandom);
    yi = 16'($urandom);
    rt = ($urandom_range(1) == 0) ? 16'($urandom_range(200, 1))
                                  : 16'($urandom_range(65535, 1));
    mh = 16'($urandom_range(100));
    th = 16'($urandom_range(100));
    dc = 16'($urandom_range(100));
    case (kind)
      SET_ZERO: begin
        // A zero control rate must freeze both integrals.
        ap = '0; ai = '0; yp = '0; yi = '0; rt = '0; mh = '0; th = '0; dc = '0;
      end
      SET_FULL: begin
        ap = '1; ai = '1; yp = '1; yi = '1; rt = '1;
        mh = 16'd100; th = 16'd100; dc = 16'd100;
      end
      SET_FAST_I: begin
        ai = '1; yi = '1; rt = 16'd1;
      end
      default: ;
    endcase
    drain_pending();
    write_register(REG_ALT_KP, ap);
    write_register(REG_ALT_KI, ai);
    write_register(REG_YAW_KP, yp);
    write_register(REG_YAW_KI, yi);
    write_register(REG_CTRL_RATE, rt);
    write_register(REG_MAIN_HOVER, mh);
    write_register(REG_TAIL_HOVER, th);
    write_register(REG_DUTY_CEIL, dc);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // Mostly values near a center, with a quarter drawn over the full field.
  function automatic logic signed [FIELD_W-1:0] near_value(input int center,
                                                           input int spread);
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'(center + int'($urandom_range(2 * spread)) - spread);
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic compare_field(input string name, input logic signed [WORD_W-1:0] exp_v,
                               input logic signed [WORD_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("main_duty", want.main_duty, main_duty);
        compare_field("tail_duty", want.tail_duty, tail_duty);
        compare_field("yaw_goal", want.yaw_goal, yaw_goal);
        compare_field("altitude_goal", want.altitude_goal, altitude_goal);
        results_checked++;
      end
    end
  end

  // Output side: a random pause after each accepted result, or a long hold-off
  // when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else if (hold_request > 0) begin
      hold_request--;
      result_stall <= 1'b1;
    end else if (result_valid && !result_stall) begin
      stall_left = draw_wait(quiet_receiver);
      result_stall <= (stall_left != 0);
    end else begin
      if (stall_left > 0) stall_left--;
      result_stall <= (stall_left != 0);
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic run_directed();
    send_request(CMD_CTRL, 16'sh0000, 16'sh0000, 16'sh0000);
    send_request(CMD_CTRL, 16'sh8000, 16'sh7fff, 16'shffff);
    send_request(CMD_CTRL, 16'sh7fff, 16'sh8000, 16'sh0000);
    send_request(CMD_IDLE_OP, 16'shffff, 16'shffff, 16'shffff);
    // Altitude steps: accepted going up at or below 90, going down above 0.
    send_request(CMD_ALT_STEP, 16'sh0000, 16'sh0000, 16'sh7fff);
    send_request(CMD_ALT_STEP, 16'sh0000, 16'sh0000, 16'sh0005);
    send_request(CMD_ALT_STEP, 16'sh0000, 16'sh0000, 16'sh8000);
    send_request(CMD_ALT_STEP, 16'sh0000, 16'sh0000, 16'shfffb);
    send_request(CMD_ALT_STEP, 16'sh0000, 16'sh0000, 16'sh0000);
    send_request(CMD_ALT_STEP, 16'sh0000, 16'sh0000, 16'sh005b);
    send_request(CMD_ALT_STEP, 16'sh0000, 16'sh0000, 16'sh0001);
    send_request(CMD_ALT_STEP, 16'sh0000, 16'sh0000, 16'sh0001);
    // Yaw steps around both wrap points and with the largest steps.
    send_request(CMD_YAW_STEP, 16'sh0000, 16'sh0000, 16'sh00b4);
    send_request(CMD_YAW_STEP, 16'sh0000, 16'sh0000, 16'sh0001);
    send_request(CMD_YAW_STEP, 16'sh0000, 16'sh0000, 16'shffff);
    send_request(CMD_YAW_STEP, 16'sh0000, 16'sh0000, 16'sh0000);
    send_request(CMD_YAW_STEP, 16'sh0000, 16'sh0000, 16'sh7fff);
    send_request(CMD_YAW_STEP, 16'sh0000, 16'sh0000, 16'sh8000);
    send_request(CMD_CTRL, 16'sh0064, 16'sh0100, 16'sh0000);
    send_request(CMD_CTRL, 16'sh8000, 16'sh8000, 16'sh0000);
    send_request(CMD_IDLE_OP, 16'sh0000, 16'sh0000, 16'sh0000);
  endtask

  task automatic run_random_phase(input int count);
    logic [CMD_W-1:0] op;
    int pick;
    int yaw_center;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 60) op = CMD_CTRL;
      else if (pick < 75) op = CMD_YAW_STEP;
      else if (pick < 90) op = CMD_ALT_STEP;
      else op = CMD_IDLE_OP;
      yaw_center = int'((longint'(yaw_goal_deg) * EDGES_PER_TURN) / DEG_PER_TURN);
      if (op == CMD_YAW_STEP)
        send_request(op, near_value(alt_goal, 150), near_value(yaw_center, 150),
                     near_value(0, 200));
      else
        send_request(op, near_value(alt_goal, 150), near_value(yaw_center, 150),
                     near_value(0, 30));
    end
  endtask

  task automatic run_setting_sweep();
    setting_kind_t kind;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      kind = (p == 0) ? SET_ZERO : (p == 1) ? SET_FULL : (p == 2) ? SET_FAST_I : SET_RANDOM;
      apply_settings(kind);
      quiet_sender = (p % 3 == 1);
      quiet_receiver = (p % 3 == 1);
      run_random_phase(PHASE_ITEMS);
    end
    quiet_sender = 1'b0;
    quiet_receiver = 1'b0;
  endtask

  // The output is held off while requests keep coming, so the block backs up.
  task automatic run_backpressure();
    drain_pending();
    quiet_sender = 1'b1;
    hold_request = 400;
    run_random_phase(30);
    quiet_sender = 1'b0;
  endtask

  // Drives the yaw target far negative so that the yaw integral and the
  // tail duty saturate at the bottom of the 32-bit range.
  task automatic run_integral_saturation();
    drain_pending();
    write_register(REG_YAW_KP, 16'hffff);
    write_register(REG_YAW_KI, 16'hffff);
    write_register(REG_CTRL_RATE, 16'd1);
    cfg_we <= 1'b0;
    settings_applied++;
    repeat (270)
      send_request(CMD_YAW_STEP, 16'($urandom), 16'($urandom), 16'sh8000);
    repeat (260)
      send_request(CMD_CTRL, near_value(alt_goal, 150), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_setting_sweep();
    run_backpressure();
    run_integral_saturation();
    drain_pending();
    repeat (100) @(posedge clk);
    $display("Covered %0d requests under %0d register settings, with a long output hold-off",
             requests_sent, settings_applied + 1);
    $display("and a saturated yaw integral; %0d results compared, %0d mismatches.",
             results_checked, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== dual_axis_pi_duty_controller_unit.f =====
sv/dapdc_pkg.sv
sv/dapdc_sdiv.sv
sv/dapdc_axis.sv
sv/dual_axis_pi_duty_controller_unit.sv
test/tb_dual_axis_pi_duty_controller_unit.sv
